// ----- hw/rtl/lbsw_pkg.sv -----
package lbsw_pkg;

	// unsigned q16 values, 65536 meaning one
	localparam int Q_W      = 17;
	localparam int Q_FRAC   = 16;
	localparam logic [Q_W-1:0] Q_ONE = 17'd65536;

	// edge zone is one eighth of a band of at most one
	localparam int EDGE_W   = 14;
	localparam int N_CELLS  = Q_FRAC;

	localparam int LUMA_W   = 18;
	localparam int CFG_IDX_W = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UNIFORM   = 2'd2;

	typedef enum logic [1:0] {
		KIND_ZERO  = 2'd0,
		KIND_ONE   = 2'd1,
		KIND_BLEND = 2'd2
	} kind_t;

	// one smoothstep ramp in flight: saturation flag, partial remainder, quotient bits
	typedef struct packed {
		logic              sat;
		logic [EDGE_W-1:0] rem;
		logic [Q_FRAC-1:0] quo;
	} lane_t;

	typedef struct packed {
		kind_t kind;
		lane_t rise;
		lane_t fall;
	} item_t;

endpackage

// ----- hw/rtl/lbsw_div_cell.sv -----
module lbsw_div_cell
	import lbsw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [EDGE_W-1:0] edge_len,
	input  logic              up_valid,
	input  item_t             up_item,
	output logic              up_stall,
	output logic              dn_valid,
	output item_t             dn_item,
	input  logic              dn_stall
);

	logic  v_q;
	item_t item_q;
	item_t item_d;
	logic  load;

	// one restoring quotient bit for a lane
	function automatic lane_t lane_step(lane_t l, logic [EDGE_W-1:0] d);
		logic [EDGE_W:0] r2;
		logic [EDGE_W:0] diff;
		logic            ge;
		lane_t           o;
		r2   = {l.rem, 1'b0};
		diff = r2 - {1'b0, d};
		ge   = (r2 >= {1'b0, d});
		o.sat = l.sat;
		o.rem = ge ? diff[EDGE_W-1:0] : r2[EDGE_W-1:0];
		o.quo = {l.quo[Q_FRAC-2:0], ge};
		return o;
	endfunction

	always_comb begin
		item_d.kind = up_item.kind;
		item_d.rise = lane_step(up_item.rise, edge_len);
		item_d.fall = lane_step(up_item.fall, edge_len);
	end

	assign up_stall = v_q & dn_stall;
	assign load     = ~up_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (load) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && up_valid) begin
			item_q <= item_d;
		end
	end

	assign dn_valid = v_q;
	assign dn_item  = item_q;

endmodule

// ----- hw/rtl/lbsw_tail.sv -----
module lbsw_tail
	import lbsw_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	input  item_t          up_item,
	output logic           up_stall,
	output logic           out_valid,
	output logic [Q_W-1:0] weight,
	input  logic           out_stall
);

	logic           v_s1, v_s2, v_s3;
	logic           stall_s1, stall_s2, stall_s3;
	kind_t          kind_s1, kind_s2;
	logic [Q_W-1:0] t2r_s1, t2f_s1;
	logic [Q_W:0]   kr_s1, kf_s1;
	logic [Q_W-1:0] rise_s2, fall_s2;
	logic [Q_W-1:0] weight_s3;

	logic [Q_W-1:0]     tr, tf;
	logic [2*Q_W-1:0]   sqr, sqf;
	logic [2*Q_W:0]     cr, cf;
	logic [Q_W-1:0]     sr, sf;
	logic [2*Q_W-1:0]   prod;
	logic [Q_W:0]       wraw;
	logic [Q_W-1:0]     wsat;
	logic [Q_W-1:0]     wsel;

	assign stall_s3 = v_s3 & out_stall;
	assign stall_s2 = v_s2 & stall_s3;
	assign stall_s1 = v_s1 & stall_s2;
	assign up_stall = stall_s1;

	// t squared and the 3 - 2t factor
	always_comb begin
		tr  = up_item.rise.sat ? Q_ONE : {1'b0, up_item.rise.quo};
		tf  = up_item.fall.sat ? Q_ONE : {1'b0, up_item.fall.quo};
		sqr = tr * tr;
		sqf = tf * tf;
	end

	// cubic term
	always_comb begin
		cr = t2r_s1 * kr_s1;
		cf = t2f_s1 * kf_s1;
		sr = cr[Q_FRAC+Q_W-1:Q_FRAC];
		sf = cf[Q_FRAC+Q_W-1:Q_FRAC];
	end

	// window product and final pick
	always_comb begin
		prod = rise_s2 * fall_s2;
		wraw = prod[2*Q_W-1:Q_FRAC];
		wsat = (wraw > {1'b0, Q_ONE}) ? Q_ONE : wraw[Q_W-1:0];
		case (kind_s2)
			KIND_ZERO:  wsel = '0;
			KIND_ONE:   wsel = Q_ONE;
			KIND_BLEND: wsel = wsat;
			default:    wsel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (!stall_s1) v_s1 <= up_valid;
			if (!stall_s2) v_s2 <= v_s1;
			if (!stall_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s1 && up_valid) begin
			kind_s1 <= up_item.kind;
			t2r_s1  <= sqr[Q_FRAC+Q_W-1:Q_FRAC];
			t2f_s1  <= sqf[Q_FRAC+Q_W-1:Q_FRAC];
			kr_s1   <= 18'd196608 - {tr, 1'b0};
			kf_s1   <= 18'd196608 - {tf, 1'b0};
		end
		if (!stall_s2 && v_s1) begin
			kind_s2 <= kind_s1;
			rise_s2 <= sr;
			fall_s2 <= Q_ONE - sf;
		end
		if (!stall_s3 && v_s2) begin
			weight_s3 <= wsel;
		end
	end

	assign out_valid = v_s3;
	assign weight    = weight_s3;

endmodule

// ----- hw/rtl/luma_band_smoothstep_weight_core.sv -----
// luma band weight: for each luma transaction gives a q16 weight (65536 = one)
// for the tonal band [band_low, band_high]. uniform_mode forces one; otherwise
// luma is clamped to [0,1], points on or outside the band get zero, and points
// inside get rising smoothstep times falling smoothstep over edge zones of one
// eighth of the band width, or one where that eighth is zero. one transaction
// is taken every clock unless a stall backs up to the input. the pipeline has
// 16 divider cells, one quotient bit each, followed by three multiply stages
// (t squared, cubic term, window product), the last of which is the output
// register. stall ripples back through the per-stage valid bits, so empty
// stages keep filling while a result waits. configuration writes are always
// accepted and must only be issued while no transaction is in flight.
module luma_band_smoothstep_weight_core
	import lbsw_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,

	// configuration write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [Q_W-1:0]          cfg_data,

	// luma input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [LUMA_W-1:0] luma,

	// weight output channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [Q_W-1:0]          weight
);

	logic [Q_W-1:0] band_low_q;
	logic [Q_W-1:0] band_high_q;
	logic           uniform_mode_q;

	// front-end band decode
	logic [Q_W-1:0]    x;
	logic [Q_W-1:0]    lo, hi;
	logic [Q_W-1:0]    width;
	logic [EDGE_W-1:0] edge_len;
	logic [Q_W-1:0]    d_rise;
	logic [Q_W-1:0]    fall_start;
	logic [Q_W-1:0]    d_fall;
	item_t             front;

	// cell chain links
	item_t chain_item  [0:N_CELLS];
	logic  chain_valid [0:N_CELLS];
	logic  chain_stall [0:N_CELLS];

	// register file, writes never stall
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_low_q     <= '0;
			band_high_q    <= Q_ONE;
			uniform_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BAND_LOW:  band_low_q     <= cfg_data;
				REG_BAND_HIGH: band_high_q    <= cfg_data;
				REG_UNIFORM:   uniform_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		// negative luma reads as zero, above one reads as one
		if (luma[LUMA_W-1]) begin
			x = '0;
		end else if (luma[Q_W-1:0] > Q_ONE) begin
			x = Q_ONE;
		end else begin
			x = luma[Q_W-1:0];
		end
		lo         = (band_low_q  > Q_ONE) ? Q_ONE : band_low_q;
		hi         = (band_high_q > Q_ONE) ? Q_ONE : band_high_q;
		width      = hi - lo;
		edge_len   = width[Q_W-1:3];
		d_rise     = x - lo;
		fall_start = hi - {3'b000, edge_len};
		d_fall     = (x > fall_start) ? (x - fall_start) : '0;

		front = '0;
		if (uniform_mode_q) begin
			front.kind = KIND_ONE;
		end else if (x <= lo || x >= hi) begin
			front.kind = KIND_ZERO;
		end else if (edge_len == '0) begin
			// band too narrow for a cross-fade
			front.kind = KIND_ONE;
		end else begin
			front.kind = KIND_BLEND;
			// past the rising zone the ramp is already at one
			if (d_rise >= {3'b000, edge_len}) begin
				front.rise.sat = 1'b1;
			end else begin
				front.rise.rem = d_rise[EDGE_W-1:0];
			end
			// x is below hi, so the falling offset stays under the edge length
			front.fall.rem = d_fall[EDGE_W-1:0];
		end
	end

	assign chain_item[0]  = front;
	assign chain_valid[0] = in_valid;
	assign in_stall       = chain_stall[0];

	// row of divider cells, each adds one quotient bit to both ramps
	for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
		lbsw_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.edge_len (edge_len),
			.up_valid (chain_valid[k]),
			.up_item  (chain_item[k]),
			.up_stall (chain_stall[k]),
			.dn_valid (chain_valid[k+1]),
			.dn_item  (chain_item[k+1]),
			.dn_stall (chain_stall[k+1])
		);
	end

	lbsw_tail u_tail (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (chain_valid[N_CELLS]),
		.up_item   (chain_item[N_CELLS]),
		.up_stall  (chain_stall[N_CELLS]),
		.out_valid (out_valid),
		.weight    (weight),
		.out_stall (out_stall)
	);

	// weight never exceeds one
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (weight <= Q_ONE))
		else $error("weight above one");

	// input can only back up when the whole chain is full and the output is held
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output backpressure");

	// a full chain stays full while the output remains stalled
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		($past(in_stall) && out_stall) |-> in_stall)
		else $error("full chain lost an entry under stall");

endmodule

// ----- tb/sv/luma_band_smoothstep_weight_core_tb.sv -----
module luma_band_smoothstep_weight_core_tb;
	import lbsw_pkg::*;

	// cycles with no transaction on any channel before the run is declared hung
	localparam int STUCK_LIMIT  = 2000;
	// room at the end after the last weight has come back
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS  = 60;
	localparam int RANDOM_PHASES = 13;
	// index 3 is not a register, writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam longint unsigned ONE_Q16 = longint'(Q_ONE);

	// weight predictor plus the queue of weights still owed by the block
	class weight_scoreboard;
		logic [Q_W-1:0] band_lo;
		logic [Q_W-1:0] band_hi;
		bit             uniform_on;
		logic [Q_W-1:0] owed_weights[$];
		int             errors;

		function new();
			band_lo    = '0;
			band_hi    = Q_ONE;
			uniform_on = 1'b0;
			errors     = 0;
		endfunction

		function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] data);
			case (idx)
				REG_BAND_LOW:  band_lo = data;
				REG_BAND_HIGH: band_hi = data;
				REG_UNIFORM:   uniform_on = data[0];
				default: ;
			endcase
		endfunction

		function longint unsigned clamp_one(longint unsigned v);
			return (v > ONE_Q16) ? ONE_Q16 : v;
		endfunction

		// q16 smoothstep over [a,b], b > a
		function longint unsigned ramp_q16(longint unsigned a, longint unsigned b,
				longint unsigned x);
			longint unsigned t;
			longint unsigned t2;
			if (x <= a) begin
				t = 0;
			end else begin
				t = clamp_one(((x - a) << 16) / (b - a));
			end
			t2 = (t * t) >> 16;
			return (t2 * (3 * ONE_Q16 - 2 * t)) >> 16;
		endfunction

		function logic [Q_W-1:0] band_weight(logic signed [LUMA_W-1:0] l);
			longint unsigned x;
			longint unsigned lo;
			longint unsigned hi;
			longint unsigned ramp;
			longint unsigned rise;
			longint unsigned fall;
			if (uniform_on) begin
				return Q_ONE;
			end
			if (l < 0) begin
				x = 0;
			end else begin
				x = clamp_one(longint'(l));
			end
			lo = clamp_one(longint'(band_lo));
			hi = clamp_one(longint'(band_hi));
			if (x <= lo || x >= hi) begin
				return '0;
			end
			ramp = (hi - lo) >> 3;
			if (ramp == 0) begin
				return Q_ONE;
			end
			rise = ramp_q16(lo, lo + ramp, x);
			fall = ONE_Q16 - ramp_q16(hi - ramp, hi, x);
			return Q_W'(clamp_one((rise * fall) >> 16));
		endfunction

		function void note_luma(logic signed [LUMA_W-1:0] l);
			owed_weights.push_back(band_weight(l));
		endfunction

		function int pending();
			return owed_weights.size();
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		task check_weight(logic [Q_W-1:0] w);
			logic [Q_W-1:0] want;
			if (owed_weights.size() == 0) begin
				report_mismatch($sformatf("weight %0d with no luma outstanding", w));
			end else begin
				want = owed_weights.pop_front();
				if (w !== want) begin
					report_mismatch($sformatf("weight %0d, expected %0d", w, want));
				end
			end
		endtask
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [Q_W-1:0]            cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [LUMA_W-1:0]  luma;
	logic                      out_valid;
	logic                      out_stall;
	logic [Q_W-1:0]            weight;

	weight_scoreboard sb;

	// band bounds as the block sees them after saturation, used to aim luma
	int band_lo_q;
	int band_hi_q;
	// set for phases that run with no gaps on either side
	bit no_gaps;
	int stuck_cycles = 0;

	luma_band_smoothstep_weight_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.luma      (luma),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.weight    (weight)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one luma transaction, preceded by a random gap, noted on acceptance
	task automatic send_luma(input int value);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		luma     <= LUMA_W'(value);
		do @(posedge clk); while (in_stall);
		sb.note_luma(LUMA_W'(value));
	endtask

	// hold the input idle until every owed weight has come back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= Q_W'(data);
		do @(posedge clk); while (!cfg_ready);
		sb.apply_write(idx, Q_W'(data));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// new band setting, only ever written with the pipeline empty
	task automatic apply_band(input int lo, input int hi, input bit uni);
		drain_results();
		if ($urandom_range(0, 3) == 0) begin
			write_reg(REG_SPARE, $urandom_range(0, 131071));
		end
		write_reg(REG_BAND_LOW, lo);
		write_reg(REG_BAND_HIGH, hi);
		// upper data bits of the mode register are don't-care
		write_reg(REG_UNIFORM, (int'($urandom_range(0, 65535)) << 1) | int'(uni));
		band_lo_q = (lo > 65536) ? 65536 : lo;
		band_hi_q = (hi > 65536) ? 65536 : hi;
		no_gaps   = ($urandom_range(0, 3) == 0);
	endtask

	// luma aimed mostly inside the band and at the edge zones, rest anywhere
	function automatic int pick_luma();
		int ramp;
		ramp = (band_hi_q > band_lo_q) ? ((band_hi_q - band_lo_q) >> 3) : 0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				if (band_hi_q > band_lo_q) begin
					return $urandom_range(band_lo_q, band_hi_q);
				end
				return $urandom_range(0, 65536);
			end
			6: return band_lo_q + int'($urandom_range(0, ramp + 2));
			7: return band_hi_q - int'($urandom_range(0, ramp + 2));
			8: return int'($urandom_range(0, 262143)) - 131072;
			default: begin
				case ($urandom_range(0, 3))
					0: return 0;
					1: return 65536;
					2: return $urandom_range(65537, 131071);
					default: return 0 - int'($urandom_range(1, 131072));
				endcase
			end
		endcase
	endfunction

	task automatic run_items(input int n);
		repeat (n) begin
			// now and then let the whole pipeline empty mid-phase
			if ($urandom_range(0, 99) == 0) begin
				drain_results();
			end
			send_luma(pick_luma());
		end
	endtask

	task automatic random_band();
		int lo;
		int hi;
		bit uni;
		lo = $urandom_range(0, 65536);
		case ($urandom_range(0, 4))
			0, 1: hi = $urandom_range(lo, 65536);
			2: hi = lo + int'($urandom_range(0, 16));
			3: begin
				// full register range, bounds above one included
				lo = $urandom_range(0, 131071);
				hi = $urandom_range(0, 131071);
			end
			default: begin
				lo = $urandom_range(0, 4096);
				hi = $urandom_range(61440, 65536);
			end
		endcase
		uni = ($urandom_range(0, 7) == 0);
		apply_band(lo, hi, uni);
	endtask

	// weight receiver: check each accepted transaction, then draw the next stall
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				sb.check_weight(weight);
				stall_left = no_gaps ? 0 : $urandom_range(0, 12);
			end
			@(negedge clk);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// hang detection: any transaction on any channel resets the count
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (stuck_cycles >= STUCK_LIMIT);
		$display("luma_band_smoothstep_weight_core_tb: FAIL");
		$finish;
	end

	initial begin : stimulus
		// default band [0,1] has edge zones of 8192: hit both ramps and their ends
		int corner_luma[$] = '{-131072, -1, 0, 1, 100, 4096, 8191, 8192, 8193, 32768,
			57343, 57344, 60000, 65535, 65536, 65537, 131071};
		// fixed settings: full band, uniform, inverted, empty, width 7 and 8,
		// both bounds above one, upper bound above one, tiny band, extremes
		int fixed_lo[$]  = '{0, 20000, 40000, 30000, 1000, 1000, 70000, 60000, 0,
			131071, 0};
		int fixed_hi[$]  = '{65536, 30000, 20000, 30000, 1007, 1008, 131071, 131071, 17,
			0, 131071};
		bit fixed_uni[$] = '{0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1};

		sb        = new();
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_BAND_LOW;
		cfg_data  = '0;
		in_valid  = 1'b0;
		luma      = '0;
		out_stall = 1'b0;
		no_gaps   = 1'b1;
		band_lo_q = 0;
		band_hi_q = 65536;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part under the reset band
		foreach (corner_luma[i]) begin
			send_luma(corner_luma[i]);
		end

		// narrow band, no cross-fade inside; spare index written once for sure
		drain_results();
		write_reg(REG_SPARE, 131071);
		apply_band(1000, 1005, 1'b0);
		send_luma(1000);
		send_luma(1001);
		send_luma(1004);
		send_luma(1005);

		// uniform mode ignores luma entirely
		apply_band(20000, 30000, 1'b1);
		send_luma(131071);
		send_luma(-131072);

		foreach (fixed_lo[i]) begin
			apply_band(fixed_lo[i], fixed_hi[i], fixed_uni[i]);
			run_items(PHASE_ITEMS);
		end

		repeat (RANDOM_PHASES) begin
			random_band();
			run_items(PHASE_ITEMS);
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("luma_band_smoothstep_weight_core_tb: PASS");
		end else begin
			$display("luma_band_smoothstep_weight_core_tb: FAIL");
		end
		$finish;
	end

endmodule
